@@ sv/pie_pkg.sv @@
// Shared types and constants for the power iteration eigenvalue block.
`default_nettype none

package pie_pkg;

  // Field widths fixed by the interface
  localparam int DATA_W = 32;
  localparam int IDX_W  = 4;
  localparam int SIZE_W = 5;
  localparam int ITER_W = 16;
  localparam int TOL_W  = 31;
  localparam int CFG_W  = 31;
  localparam int CFG_IDX_W = 2;

  // Input commands
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_RUN  = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MATRIX_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE   = 2'd2;

  // Configuration reset values
  localparam logic [SIZE_W-1:0] RST_MATRIX_SIZE = 5'd16;
  localparam logic [ITER_W-1:0] RST_MAX_ITER    = 16'd100;
  localparam logic [TOL_W-1:0]  RST_TOLERANCE   = 31'd1;

  localparam logic signed [DATA_W-1:0] SAT_HI = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] SAT_LO = 32'sh8000_0000;

  typedef enum logic [4:0] {
    S_IDLE,
    S_INIT_WAIT,
    S_CHECK,
    S_MV_RD,
    S_MV_MUL,
    S_MV_ACC,
    S_DOT_RD,
    S_DOT_MUL,
    S_DOT_ACC,
    S_EIG,
    S_EIG_WAIT,
    S_SC_RD,
    S_SC,
    S_SC_WAIT,
    S_UPD,
    S_OUT
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_INIT_DIV,
    OP_INIT_SET,
    OP_MV_RD,
    OP_MV_MUL,
    OP_MV_ACC,
    OP_DOT_RD,
    OP_DOT_MUL,
    OP_DOT_ACC,
    OP_EIG_DIV,
    OP_EIG_ZERO,
    OP_EIG_SET,
    OP_SC_RD,
    OP_SC_DIV,
    OP_SC_ZERO,
    OP_SC_SET,
    OP_UPD,
    OP_EMIT
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic i_last;
    logic j_last;
    logic div_done;
    logic pass_limit;
    logic conv_hit;
    logic den_zero;
    logic max_zero;
  } status_t;

endpackage

`default_nettype wire

@@ sv/power_iteration_dominant_eigen_top.sv @@
// Top level of the power iteration dominant eigenvalue block.
//
//   channel  | handshake          | payload
//   ---------+--------------------+----------------------------------------------
//   input    | start & !busy      | in_command, in_row, in_col, in_value
//   result   | out_valid (strobe) | out_eigenvalue, out_vector_element,
//            |                    | out_element_index, out_iterations_used,
//            |                    | out_converged, out_last
//   config   | cfg_we             | cfg_index, cfg_data
//
// A load word is written to the matrix memory and busy stays low. A run word
// keeps busy high for: one initial divide, then per pass the matrix-vector
// product, the dot products, one eigen divide (skipped when v.v is zero) and
// n scaling steps, each a divide (skipped when the product is all zero),
// plus the pass check and update; one more check when the pass limit ends
// the run; then n result words, one per cycle.
// D = FRACTION_BITS + 35 + 2*clog2(MAX_ORDER) is the bit count of the
// shared serial divider; the pass time is set by that divider and the single
// matrix memory read port. Reset is synchronous: it clears the controller and
// the strobe and loads the configuration reset values; matrix contents stay
// undefined until loaded. Result words leave without backpressure.
`default_nettype none

module power_iteration_dominant_eigen_top #(
  parameter int MAX_ORDER     = 16,
  parameter int FRACTION_BITS = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic                               in_command,
  input  wire logic [pie_pkg::IDX_W-1:0]          in_row,
  input  wire logic [pie_pkg::IDX_W-1:0]          in_col,
  input  wire logic signed [pie_pkg::DATA_W-1:0]  in_value,
  output logic                                    out_valid,
  output logic signed [pie_pkg::DATA_W-1:0]       out_eigenvalue,
  output logic signed [pie_pkg::DATA_W-1:0]       out_vector_element,
  output logic [pie_pkg::IDX_W-1:0]               out_element_index,
  output logic [pie_pkg::ITER_W-1:0]              out_iterations_used,
  output logic                                    out_converged,
  output logic                                    out_last,
  input  wire logic                               cfg_we,
  input  wire logic [pie_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [pie_pkg::CFG_W-1:0]          cfg_data
);

  // configuration registers
  logic [pie_pkg::SIZE_W-1:0] matrix_size_r;
  logic [pie_pkg::ITER_W-1:0] max_iter_r;
  logic [pie_pkg::TOL_W-1:0]  tol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      matrix_size_r <= pie_pkg::RST_MATRIX_SIZE;
      max_iter_r    <= pie_pkg::RST_MAX_ITER;
      tol_r         <= pie_pkg::RST_TOLERANCE;
    end else if (cfg_we) begin
      case (cfg_index)
        pie_pkg::CFG_MATRIX_SIZE: matrix_size_r <= cfg_data[pie_pkg::SIZE_W-1:0];
        pie_pkg::CFG_MAX_ITER:    max_iter_r    <= cfg_data[pie_pkg::ITER_W-1:0];
        pie_pkg::CFG_TOLERANCE:   tol_r         <= cfg_data[pie_pkg::TOL_W-1:0];
        default:                  tol_r         <= tol_r;
      endcase
    end
  end

  pie_pkg::cmd_t    cmd;
  pie_pkg::status_t st;

  pie_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_command (in_command),
    .st         (st),
    .cmd        (cmd),
    .busy       (busy)
  );

  pie_dp #(
    .MAX_ORDER     (MAX_ORDER),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .st                  (st),
    .in_row              (in_row),
    .in_col              (in_col),
    .in_value            (in_value),
    .matrix_size         (matrix_size_r),
    .max_iterations      (max_iter_r),
    .tolerance           (tol_r),
    .out_valid           (out_valid),
    .out_eigenvalue      (out_eigenvalue),
    .out_vector_element  (out_vector_element),
    .out_element_index   (out_element_index),
    .out_iterations_used (out_iterations_used),
    .out_converged       (out_converged),
    .out_last            (out_last)
  );

endmodule

`default_nettype wire

@@ sv/pie_div.sv @@
// Restoring divider, one quotient bit per cycle: (num << F) / den.
`default_nettype none

module pie_div #(
  parameter int DNW = 43,
  parameter int DSW = 38,
  parameter int F   = 16
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  wire logic [DNW-1:0] num,
  input  wire logic [DSW-1:0] den,
  output logic                done,
  output logic [DNW+F-1:0]    quo
);

  localparam int DVW = DNW + F;
  localparam int CW  = $clog2(DVW + 1);

  logic [DVW-1:0] quo_r;
  logic [DSW-1:0] rem_r;
  logic [DSW-1:0] den_r;
  logic [CW-1:0]  cnt_r;
  logic           run_r;
  logic           done_r;

  logic [DSW:0] trial;
  logic [DSW:0] diff;
  logic         ge;

  assign trial = {rem_r, quo_r[DVW-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CW'(DVW);
      end else if (run_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= {num, {F{1'b0}}};
      rem_r <= '0;
      den_r <= den;
    end else if (run_r) begin
      rem_r <= ge ? diff[DSW-1:0] : trial[DSW-1:0];
      quo_r <= {quo_r[DVW-2:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

`default_nettype wire

@@ sv/pie_dp.sv @@
// Datapath: matrix memory, vectors, multiply-accumulate, divider and results.
`default_nettype none

module pie_dp #(
  parameter int MAX_ORDER     = 16,
  parameter int FRACTION_BITS = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire pie_pkg::cmd_t                    cmd,
  output pie_pkg::status_t                      st,
  input  wire logic [pie_pkg::IDX_W-1:0]        in_row,
  input  wire logic [pie_pkg::IDX_W-1:0]        in_col,
  input  wire logic signed [pie_pkg::DATA_W-1:0] in_value,
  input  wire logic [pie_pkg::SIZE_W-1:0]       matrix_size,
  input  wire logic [pie_pkg::ITER_W-1:0]       max_iterations,
  input  wire logic [pie_pkg::TOL_W-1:0]        tolerance,
  output logic                                  out_valid,
  output logic signed [pie_pkg::DATA_W-1:0]     out_eigenvalue,
  output logic signed [pie_pkg::DATA_W-1:0]     out_vector_element,
  output logic [pie_pkg::IDX_W-1:0]             out_element_index,
  output logic [pie_pkg::ITER_W-1:0]            out_iterations_used,
  output logic                                  out_converged,
  output logic                                  out_last
);

  localparam int F     = FRACTION_BITS;
  localparam int IW    = $clog2(MAX_ORDER);
  localparam int NCW   = $clog2(MAX_ORDER + 1);
  localparam int DEPTH = MAX_ORDER * MAX_ORDER;
  localparam int AW    = $clog2(DEPTH);
  localparam int VMW   = F + 1;            // vector magnitude, up to one
  localparam int VW    = F + 2;            // signed vector element
  localparam int PW    = 34 + IW;          // signed product element
  localparam int MW    = PW + VMW;         // multiplier output
  localparam int NMW   = PW + 1 + IW;      // v.Av magnitude
  localparam int NSW   = NMW + 1;
  localparam int DENW  = F + 2 + IW;       // v.v
  localparam int DVW   = NMW + F;          // quotient width
  localparam logic signed [pie_pkg::DATA_W-1:0] E_ONE = 32'sd1 <<< F;
  localparam logic [DVW-1:0] Q_POS_MAX = DVW'(32'h7FFF_FFFF);
  localparam logic [DVW-1:0] Q_NEG_MAX = DVW'(32'h8000_0000);

  logic signed [pie_pkg::DATA_W-1:0] mem [DEPTH];
  logic signed [pie_pkg::DATA_W-1:0] mem_q_r;

  logic signed [VW-1:0] v_r [MAX_ORDER];
  logic signed [PW-1:0] p_r [MAX_ORDER];

  logic [NCW-1:0]        n_r;
  logic [IW-1:0]         i_r, j_r;
  logic signed [PW-1:0]  acc_r;
  logic signed [VW-1:0]  va_r;
  logic signed [PW-1:0]  pi_r;
  logic [MW-1:0]         prod_a_r;
  logic [2*VMW-1:0]      prod_b_r;
  logic                  neg_r;
  logic signed [NSW-1:0] num_r;
  logic [DENW-1:0]       den_r;
  logic [PW-1:0]         maxv_r;
  logic signed [pie_pkg::DATA_W-1:0] next_r, eig_r;
  logic [pie_pkg::ITER_W-1:0] pass_r;
  logic                  conv_r;
  logic                  out_valid_r;

  pie_pkg::op_t op;
  assign op = cmd.op;

  // ---- clamped order ----
  logic [NCW-1:0] n_clamp;
  always_comb begin
    if (matrix_size == '0) n_clamp = NCW'(1);
    else if (int'(matrix_size) > MAX_ORDER) n_clamp = NCW'(MAX_ORDER);
    else n_clamp = NCW'(matrix_size);
  end

  logic i_last, j_last;
  assign i_last = (NCW'(i_r) + NCW'(1)) == n_r;
  assign j_last = (NCW'(j_r) + NCW'(1)) == n_r;

  // ---- matrix memory ----
  logic          ld_ok;
  logic [AW-1:0] wr_addr, rd_addr;
  assign ld_ok   = (int'(in_row) < MAX_ORDER) && (int'(in_col) < MAX_ORDER);
  assign wr_addr = AW'(int'(in_row) * MAX_ORDER + int'(in_col));
  assign rd_addr = AW'(int'(i_r) * MAX_ORDER + int'(j_r));

  always_ff @(posedge clk) begin
    if (op == pie_pkg::OP_LOAD && ld_ok) begin
      mem[wr_addr] <= in_value;
    end
    mem_q_r <= mem[rd_addr];
  end

  // ---- magnitudes ----
  logic [IW-1:0]    vidx;
  logic signed [VW-1:0] v_rd;
  logic [VMW-1:0]   va_mag;
  logic [PW-1:0]    pi_mag;
  logic [32:0]      mem_ext;
  logic [32:0]      mem_abs;
  logic [PW-1:0]    mem_mag;
  logic [VW-1:0]    va_abs;

  assign vidx    = (op == pie_pkg::OP_MV_RD) ? j_r : i_r;
  assign v_rd    = v_r[vidx];
  assign va_abs  = va_r[VW-1] ? VW'(-va_r) : VW'(va_r);
  assign va_mag  = va_abs[VMW-1:0];
  assign pi_mag  = pi_r[PW-1] ? PW'(-pi_r) : PW'(pi_r);
  assign mem_ext = {mem_q_r[31], mem_q_r};
  assign mem_abs = mem_q_r[31] ? 33'(-mem_ext) : mem_ext;
  assign mem_mag = PW'(mem_abs[31:0]);

  // ---- multiplier (one per cycle) ----
  logic [PW-1:0] mul_a;
  assign mul_a = (op == pie_pkg::OP_MV_MUL) ? mem_mag : pi_mag;

  // ---- accumulate terms ----
  logic [PW-1:0]        tmag;
  logic signed [PW-1:0] mv_term, acc_sum;
  logic [NSW-1:0]       nmag;
  logic signed [NSW-1:0] n_term;
  logic [DENW-1:0]      d_term;

  assign tmag    = {1'b0, prod_a_r[F +: PW-1]};
  assign mv_term = neg_r ? -$signed(tmag) : $signed(tmag);
  assign acc_sum = acc_r + mv_term;
  assign nmag    = NSW'(prod_a_r[MW-1:F]);
  assign n_term  = neg_r ? -$signed(nmag) : $signed(nmag);
  assign d_term  = DENW'(prod_b_r[2*VMW-1:F]);

  // ---- divider ----
  logic           div_start, div_done;
  logic [NMW-1:0] div_num;
  logic [PW-1:0]  div_den;
  logic [DVW-1:0] quo;
  logic [NSW-1:0] num_abs;

  assign num_abs = num_r[NSW-1] ? NSW'(-num_r) : NSW'(num_r);

  always_comb begin
    div_start = 1'b0;
    div_num   = NMW'(1);
    div_den   = PW'(n_clamp);
    case (op)
      pie_pkg::OP_INIT_DIV: begin
        div_start = 1'b1;
      end
      pie_pkg::OP_EIG_DIV: begin
        div_start = 1'b1;
        div_num   = num_abs[NMW-1:0];
        div_den   = PW'(den_r);
      end
      pie_pkg::OP_SC_DIV: begin
        div_start = 1'b1;
        div_num   = NMW'(pi_mag);
        div_den   = maxv_r;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  pie_div #(
    .DNW (NMW),
    .DSW (PW),
    .F   (F)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (quo)
  );

  // saturated signed estimate from the quotient
  logic signed [pie_pkg::DATA_W-1:0] eig_q;
  always_comb begin
    if (num_r[NSW-1]) begin
      eig_q = (quo > Q_NEG_MAX) ? pie_pkg::SAT_LO : -$signed(quo[31:0]);
    end else begin
      eig_q = (quo > Q_POS_MAX) ? pie_pkg::SAT_HI : $signed(quo[31:0]);
    end
  end

  logic signed [VW-1:0] sc_q;
  assign sc_q = pi_r[PW-1] ? -$signed(quo[VW-1:0]) : $signed(quo[VW-1:0]);

  // ---- convergence test ----
  logic signed [32:0] delta;
  logic [32:0]        dabs;
  assign delta = 33'(next_r) - 33'(eig_r);
  assign dabs  = delta[32] ? 33'(-delta) : 33'(delta);

  // ---- control registers ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_r         <= '0;
      j_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (op == pie_pkg::OP_EMIT);
      case (op)
        pie_pkg::OP_INIT_SET: begin
          i_r <= '0;
          j_r <= '0;
        end
        pie_pkg::OP_MV_ACC: begin
          if (j_last) begin
            j_r <= '0;
            i_r <= i_last ? '0 : i_r + IW'(1);
          end else begin
            j_r <= j_r + IW'(1);
          end
        end
        pie_pkg::OP_DOT_ACC, pie_pkg::OP_SC_ZERO, pie_pkg::OP_SC_SET,
        pie_pkg::OP_EMIT: begin
          i_r <= i_last ? '0 : i_r + IW'(1);
        end
        pie_pkg::OP_UPD: begin
          i_r <= '0;
        end
        default: begin
          i_r <= i_r;
        end
      endcase
    end
  end

  // ---- payload registers ----
  always_ff @(posedge clk) begin
    case (op)
      pie_pkg::OP_INIT_DIV: begin
        n_r    <= n_clamp;
        eig_r  <= E_ONE;
        pass_r <= '0;
        conv_r <= 1'b0;
      end
      pie_pkg::OP_INIT_SET: begin
        acc_r <= '0;
        for (int k = 0; k < MAX_ORDER; k++) begin
          v_r[k] <= $signed(quo[VW-1:0]);
        end
      end
      pie_pkg::OP_MV_RD, pie_pkg::OP_DOT_RD: begin
        va_r <= v_rd;
        pi_r <= p_r[i_r];
      end
      pie_pkg::OP_MV_MUL: begin
        prod_a_r <= MW'(mul_a) * MW'(va_mag);
        neg_r    <= mem_q_r[31] ^ va_r[VW-1];
      end
      pie_pkg::OP_MV_ACC: begin
        if (j_last) begin
          p_r[i_r] <= acc_sum;
          acc_r    <= '0;
          if (i_last) begin
            num_r  <= '0;
            den_r  <= '0;
            maxv_r <= '0;
          end
        end else begin
          acc_r <= acc_sum;
        end
      end
      pie_pkg::OP_DOT_MUL: begin
        prod_a_r <= MW'(mul_a) * MW'(va_mag);
        prod_b_r <= (2*VMW)'(va_mag) * (2*VMW)'(va_mag);
        neg_r    <= pi_r[PW-1] ^ va_r[VW-1];
        if (pi_mag > maxv_r) maxv_r <= pi_mag;
      end
      pie_pkg::OP_DOT_ACC: begin
        num_r <= num_r + n_term;
        den_r <= den_r + d_term;
      end
      pie_pkg::OP_EIG_ZERO: begin
        next_r <= '0;
      end
      pie_pkg::OP_EIG_SET: begin
        next_r <= eig_q;
      end
      pie_pkg::OP_SC_RD: begin
        pi_r <= p_r[i_r];
      end
      pie_pkg::OP_SC_ZERO: begin
        v_r[i_r] <= '0;
      end
      pie_pkg::OP_SC_SET: begin
        v_r[i_r] <= sc_q;
      end
      pie_pkg::OP_UPD: begin
        eig_r  <= next_r;
        pass_r <= pass_r + pie_pkg::ITER_W'(1);
        conv_r <= dabs < {2'b00, tolerance};
      end
      pie_pkg::OP_EMIT: begin
        out_eigenvalue      <= eig_r;
        out_vector_element  <= pie_pkg::DATA_W'(v_rd);
        out_element_index   <= pie_pkg::IDX_W'(i_r);
        out_iterations_used <= pass_r;
        out_converged       <= conv_r;
        out_last            <= i_last;
      end
      default: begin
        neg_r <= neg_r;
      end
    endcase
  end

  assign out_valid = out_valid_r;

  always_comb begin
    st.i_last     = i_last;
    st.j_last     = j_last;
    st.div_done   = div_done;
    st.pass_limit = pass_r >= max_iterations;
    st.conv_hit   = dabs < {2'b00, tolerance};
    st.den_zero   = den_r == '0;
    st.max_zero   = maxv_r == '0;
  end

endmodule

`default_nettype wire

@@ sv/pie_ctrl.sv @@
// Controller: sequences loads, iteration passes and the result words.
`default_nettype none

module pie_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic             in_command,
  input  wire pie_pkg::status_t st,
  output pie_pkg::cmd_t         cmd,
  output logic                  busy
);

  pie_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pie_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd.op    = pie_pkg::OP_NONE;
    busy      = 1'b1;
    case (state_r)
      pie_pkg::S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          if (in_command == pie_pkg::CMD_LOAD) begin
            cmd.op = pie_pkg::OP_LOAD;
          end else begin
            cmd.op    = pie_pkg::OP_INIT_DIV;
            state_nxt = pie_pkg::S_INIT_WAIT;
          end
        end
      end
      pie_pkg::S_INIT_WAIT: begin
        if (st.div_done) begin
          cmd.op    = pie_pkg::OP_INIT_SET;
          state_nxt = pie_pkg::S_CHECK;
        end
      end
      pie_pkg::S_CHECK: begin
        state_nxt = st.pass_limit ? pie_pkg::S_OUT : pie_pkg::S_MV_RD;
      end
      pie_pkg::S_MV_RD: begin
        cmd.op    = pie_pkg::OP_MV_RD;
        state_nxt = pie_pkg::S_MV_MUL;
      end
      pie_pkg::S_MV_MUL: begin
        cmd.op    = pie_pkg::OP_MV_MUL;
        state_nxt = pie_pkg::S_MV_ACC;
      end
      pie_pkg::S_MV_ACC: begin
        cmd.op    = pie_pkg::OP_MV_ACC;
        state_nxt = (st.i_last && st.j_last) ? pie_pkg::S_DOT_RD : pie_pkg::S_MV_RD;
      end
      pie_pkg::S_DOT_RD: begin
        cmd.op    = pie_pkg::OP_DOT_RD;
        state_nxt = pie_pkg::S_DOT_MUL;
      end
      pie_pkg::S_DOT_MUL: begin
        cmd.op    = pie_pkg::OP_DOT_MUL;
        state_nxt = pie_pkg::S_DOT_ACC;
      end
      pie_pkg::S_DOT_ACC: begin
        cmd.op    = pie_pkg::OP_DOT_ACC;
        state_nxt = st.i_last ? pie_pkg::S_EIG : pie_pkg::S_DOT_RD;
      end
      pie_pkg::S_EIG: begin
        if (st.den_zero) begin
          cmd.op    = pie_pkg::OP_EIG_ZERO;
          state_nxt = pie_pkg::S_SC_RD;
        end else begin
          cmd.op    = pie_pkg::OP_EIG_DIV;
          state_nxt = pie_pkg::S_EIG_WAIT;
        end
      end
      pie_pkg::S_EIG_WAIT: begin
        if (st.div_done) begin
          cmd.op    = pie_pkg::OP_EIG_SET;
          state_nxt = pie_pkg::S_SC_RD;
        end
      end
      pie_pkg::S_SC_RD: begin
        cmd.op    = pie_pkg::OP_SC_RD;
        state_nxt = pie_pkg::S_SC;
      end
      pie_pkg::S_SC: begin
        if (st.max_zero) begin
          cmd.op    = pie_pkg::OP_SC_ZERO;
          state_nxt = st.i_last ? pie_pkg::S_UPD : pie_pkg::S_SC_RD;
        end else begin
          cmd.op    = pie_pkg::OP_SC_DIV;
          state_nxt = pie_pkg::S_SC_WAIT;
        end
      end
      pie_pkg::S_SC_WAIT: begin
        if (st.div_done) begin
          cmd.op    = pie_pkg::OP_SC_SET;
          state_nxt = st.i_last ? pie_pkg::S_UPD : pie_pkg::S_SC_RD;
        end
      end
      pie_pkg::S_UPD: begin
        cmd.op    = pie_pkg::OP_UPD;
        state_nxt = st.conv_hit ? pie_pkg::S_OUT : pie_pkg::S_CHECK;
      end
      pie_pkg::S_OUT: begin
        cmd.op    = pie_pkg::OP_EMIT;
        state_nxt = st.i_last ? pie_pkg::S_IDLE : pie_pkg::S_OUT;
      end
      default: begin
        state_nxt = pie_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire
